FILE: hdl/hwct_pkg.sv
package hwct_pkg;

  localparam int unsigned Buckets   = 1024;
  localparam int unsigned Ways      = 4;
  localparam int unsigned MaxChars  = 20;
  localparam int unsigned KeyBytes  = 20;
  localparam int unsigned BucketW   = $clog2(Buckets);
  localparam int unsigned WayW      = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned EntryW    = 64 + 64 + 32 + 32;
  localparam logic [31:0] HashMult  = 32'd31;
  localparam logic [31:0] CountMax  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FuncIncr  = 2'd0,
    FuncQuery = 2'd1,
    FuncClear = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StHash,
    StRead,
    StMerge,
    StOut
  } state_e;

  typedef struct packed {
    logic [31:0] khi;
    logic [63:0] kmi;
    logic [63:0] klo;
  } key_t;

  // per-lane compare result toward the merge stage
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [31:0] count;
  } lane_res_t;

endpackage

FILE: hdl/hashed_word_count_table.sv
// Word counting hash table. Each input word carries a function (increment,
// query, clear) and a key of up to 20 bytes; exactly one result word follows.
// The key is hashed one byte per cycle, then the bucket is read from all ways
// in parallel lanes, merged and written back, and the result is registered; a
// new word is accepted only once the previous result has been taken.
// Increments and clears of a new key into a full bucket are dropped and flagged.
// After reset a clearing pass zeroes the valid bits of every bucket; no word is
// accepted until it has finished.
module hashed_word_count_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [1:0] func, [65:2] key_low, [129:66] key_mid, [161:130] key_high
  input  logic [167:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [31:0] count, [32] found, [33] dropped
  output logic [39:0]   m_axis_tdata_o
);
  hwct_pkg::state_e state_q, state_d;
  logic [1:0]   func_q;
  logic [31:0]  ocount_q, ocount_d;
  logic         ofound_q, ofound_d, odrop_q, odrop_d;
  logic [31:0]  hash;
  logic         hdone, start;
  hwct_pkg::key_t key, raw;
  logic [hwct_pkg::BucketW-1:0] bucket_q;
  logic [hwct_pkg::BucketW-1:0] clr_q;
  logic         init;
  hwct_pkg::lane_res_t res [hwct_pkg::Ways];
  logic         hit, free;
  logic [hwct_pkg::WayW-1:0] way;
  logic [31:0]  mcount;
  logic         wr_en, wr_key;
  logic [31:0]  wr_count;

  assign raw   = s_axis_tdata_i[161:2];
  assign start = s_axis_tvalid_i && s_axis_tready_o;
  assign init  = (state_q == hwct_pkg::StInit);

  hwct_hash u_hash (
    .clk_i, .rst_ni, .start_i(start), .raw_i(raw),
    .done_o(hdone), .key_o(key), .hash_o(hash)
  );

  // during the clearing pass every lane writes an invalid slot per cycle
  for (genvar w = 0; w < hwct_pkg::Ways; w++) begin : g_lane
    hwct_lane u_lane (
      .clk_i, .rst_ni,
      .rd_addr_i(bucket_q), .key_i(key),
      .wr_en_i(init || (wr_en && way == hwct_pkg::WayW'(w))), .wr_key_i(wr_key),
      .wr_valid_i(!init),
      .wr_addr_i(init ? clr_q : bucket_q), .wr_count_i(wr_count), .res_o(res[w])
    );
  end

  hwct_merge u_merge (
    .res_i(res), .hit_o(hit), .free_o(free), .way_o(way), .count_o(mcount)
  );

  always_ff @(posedge clk_i) begin
    if (start) func_q <= s_axis_tdata_i[1:0];
    if (hdone) bucket_q <= hash[hwct_pkg::BucketW-1:0];
    ocount_q <= ocount_d;
    ofound_q <= ofound_d;
    odrop_q  <= odrop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hwct_pkg::StInit;
    else         state_q <= state_d;
  end

  // advance the clearing address once per cycle of the pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)   clr_q <= '0;
    else if (init) clr_q <= clr_q + 1'b1;
  end

  always_comb begin
    logic upd;
    state_d  = state_q;
    ocount_d = ocount_q; ofound_d = ofound_q; odrop_d = odrop_q;
    wr_en = 1'b0; wr_key = 1'b0; wr_count = '0;
    upd = (func_q == hwct_pkg::FuncIncr) || (func_q == hwct_pkg::FuncClear);
    unique case (state_q)
      hwct_pkg::StInit:  begin
        if (clr_q == hwct_pkg::BucketW'(hwct_pkg::Buckets - 1)) state_d = hwct_pkg::StIdle;
      end
      hwct_pkg::StIdle:  if (start) state_d = hwct_pkg::StHash;
      hwct_pkg::StHash:  if (hdone) state_d = hwct_pkg::StRead;
      hwct_pkg::StRead:  state_d = hwct_pkg::StMerge;
      hwct_pkg::StMerge: begin
        // write back the updated count, or insert into the lowest free way, or flag a drop
        state_d = hwct_pkg::StOut;
        ofound_d = hit; odrop_d = 1'b0; ocount_d = '0;
        if (hit) begin
          ocount_d = mcount;
          if (func_q == hwct_pkg::FuncIncr) begin
            ocount_d = (mcount == hwct_pkg::CountMax) ? mcount : mcount + 32'd1;
          end else if (func_q == hwct_pkg::FuncClear) begin
            ocount_d = '0;
          end
          wr_en = upd; wr_count = ocount_d;
        end else if (upd) begin
          if (free) begin
            ocount_d = (func_q == hwct_pkg::FuncIncr) ? 32'd1 : 32'd0;
            wr_en = 1'b1; wr_key = 1'b1; wr_count = ocount_d;
          end else begin
            odrop_d = 1'b1;
          end
        end
      end
      hwct_pkg::StOut:   if (m_axis_tready_i) state_d = hwct_pkg::StIdle;
      default:           state_d = hwct_pkg::StIdle;
    endcase
  end

  assign s_axis_tready_o = (state_q == hwct_pkg::StIdle);
  assign m_axis_tvalid_o = (state_q == hwct_pkg::StOut);
  assign m_axis_tdata_o  = {6'd0, odrop_q, ofound_q, ocount_q};

  // a result never claims both a hit and a drop
  a_hit_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[32] && m_axis_tdata_o[33]))
    else $error("found and dropped together");

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // no input accepted while a result is pending
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input accepted with result pending");
endmodule

FILE: hdl/hwct_lane.sv
// One way of the table: entry memory, valid bits and the key compare.
module hwct_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [hwct_pkg::BucketW-1:0]    rd_addr_i,
  input  hwct_pkg::key_t                  key_i,
  input  logic                            wr_en_i,
  input  logic                            wr_key_i,
  input  logic                            wr_valid_i,
  input  logic [hwct_pkg::BucketW-1:0]    wr_addr_i,
  input  logic [31:0]                     wr_count_i,
  output hwct_pkg::lane_res_t             res_o
);
  logic [hwct_pkg::EntryW-1:0] mem [hwct_pkg::Buckets];
  logic                        vmem [hwct_pkg::Buckets];
  logic [hwct_pkg::EntryW-1:0] rd_q;
  logic                        rd_valid_q;

  // key write replaces whole entry; count-only write keeps the stored key
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (wr_key_i) begin
        mem[wr_addr_i] <= {key_i, wr_count_i};
      end else begin
        mem[wr_addr_i][31:0] <= wr_count_i;
      end
      vmem[wr_addr_i] <= wr_valid_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= vmem[rd_addr_i];
    end
  end

  assign res_o.valid = rd_valid_q;
  assign res_o.hit   = rd_valid_q && (rd_q[hwct_pkg::EntryW-1:32] == key_i);
  assign res_o.count = rd_q[31:0];
endmodule

FILE: hdl/hwct_hash.sv
// Normalize the word and fold its bytes into h = h*31 + byte, one byte a cycle.
module hwct_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hwct_pkg::key_t      raw_i,
  output logic                done_o,
  output hwct_pkg::key_t      key_o,
  output logic [31:0]         hash_o
);
  localparam int unsigned IdxW = $clog2(hwct_pkg::KeyBytes + 1);
  logic [8*hwct_pkg::KeyBytes-1:0] bytes_q, bytes_d;
  logic [31:0]     hash_q;
  logic [IdxW-1:0] idx_q;
  logic            busy_q;
  logic [7:0]      cur;

  // clear everything from the first zero byte or past the character limit
  always_comb begin
    logic ended;
    logic [8*hwct_pkg::KeyBytes-1:0] r;
    ended = 1'b0;
    r = {raw_i.khi, raw_i.kmi, raw_i.klo};
    for (int i = 0; i < hwct_pkg::KeyBytes; i++) begin
      if (i >= hwct_pkg::MaxChars || r[8*i +: 8] == 8'd0) ended = 1'b1;
      bytes_d[8*i +: 8] = ended ? 8'd0 : r[8*i +: 8];
    end
  end

  assign cur = bytes_q[8*idx_q[IdxW-1:0] +: 8];

  always_ff @(posedge clk_i) begin
    if (start_i) bytes_q <= bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      hash_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      hash_q <= '0;
    end else if (busy_q) begin
      if (idx_q == IdxW'(hwct_pkg::KeyBytes) || cur == 8'd0) begin
        busy_q <= 1'b0;
      end else begin
        hash_q <= hash_q * hwct_pkg::HashMult + {24'd0, cur};
        idx_q  <= idx_q + 1'b1;
      end
    end
  end

  assign done_o = busy_q && (idx_q == IdxW'(hwct_pkg::KeyBytes) || cur == 8'd0);
  assign key_o  = bytes_q;
  assign hash_o = hash_q;
endmodule

FILE: hdl/hwct_merge.sv
// Combine the lane results: first hit wins, else lowest free way.
module hwct_merge (
  input  hwct_pkg::lane_res_t           res_i [hwct_pkg::Ways],
  output logic                          hit_o,
  output logic                          free_o,
  output logic [hwct_pkg::WayW-1:0]     way_o,
  output logic [31:0]                   count_o
);
  always_comb begin
    logic [hwct_pkg::WayW-1:0] fw;
    hit_o = 1'b0; free_o = 1'b0; way_o = '0; count_o = '0; fw = '0;
    for (int w = hwct_pkg::Ways - 1; w >= 0; w--) begin
      if (res_i[w].hit) begin
        hit_o = 1'b1; way_o = hwct_pkg::WayW'(w); count_o = res_i[w].count;
      end
      if (!res_i[w].valid) begin
        free_o = 1'b1; fw = hwct_pkg::WayW'(w);
      end
    end
    if (!hit_o) way_o = fw;
  end
endmodule
